// File: src/udc_pkg.sv
// Shared types and constants for the ultrasonic door controller.
// Depends on nothing; used by ultrasonic_door_controller.
package udc_pkg;

  // Sequencer phase codes
  localparam logic [2:0] PH_SETTLE = 3'd0;
  localparam logic [2:0] PH_TRIG   = 3'd1;
  localparam logic [2:0] PH_WAIT   = 3'd2;
  localparam logic [2:0] PH_MEAS   = 3'd3;
  localparam logic [2:0] PH_GAP    = 3'd4;
  localparam logic [2:0] PH_GRACE  = 3'd5;

  // Configuration register indexes
  localparam logic [3:0] REG_NEAR_TICKS      = 4'd0;
  localparam logic [3:0] REG_FAR_TICKS       = 4'd1;
  localparam logic [3:0] REG_OPEN_PULSE_US   = 4'd2;
  localparam logic [3:0] REG_CLOSED_PULSE_US = 4'd3;
  localparam logic [3:0] REG_ECHO_WAIT_LIMIT = 4'd4;
  localparam logic [3:0] REG_CLOSED_GAP_US   = 4'd5;
  localparam logic [3:0] REG_OPEN_GAP_US     = 4'd6;
  localparam logic [3:0] REG_GRACE_US        = 4'd7;

  // Configuration reset values
  localparam logic [15:0] RST_NEAR_TICKS      = 16'd1166;
  localparam logic [15:0] RST_FAR_TICKS       = 16'd1458;
  localparam logic [11:0] RST_OPEN_PULSE_US   = 12'd2000;
  localparam logic [11:0] RST_CLOSED_PULSE_US = 12'd1000;
  localparam logic [15:0] RST_ECHO_WAIT_LIMIT = 16'd30000;
  localparam logic [19:0] RST_CLOSED_GAP_US   = 20'd100000;
  localparam logic [19:0] RST_OPEN_GAP_US     = 20'd50000;
  localparam logic [19:0] RST_GRACE_US        = 20'd800000;

  // Servo pulse limits and reset pulse
  localparam logic [11:0] PULSE_MIN   = 12'd500;
  localparam logic [11:0] PULSE_MAX   = 12'd2500;
  localparam logic [11:0] PULSE_RESET = 12'd1000;

  // One result transaction
  typedef struct packed {
    logic        trigger_level;
    logic        servo_pwm;
    logic        door_open;
    logic        measure_done;
    logic        no_echo;
    logic [15:0] echo_width;
  } res_t;

  // Clamp a servo pulse width into the legal range
  function automatic logic [11:0] clamp_pulse(input logic [11:0] p);
    logic [11:0] r;
    if (p < PULSE_MIN) begin
      r = PULSE_MIN;
    end else if (p > PULSE_MAX) begin
      r = PULSE_MAX;
    end else begin
      r = p;
    end
    return r;
  endfunction

endpackage

// File: src/ultrasonic_door_controller.sv
// Ultrasonic door controller top level: ranging sequencer, door logic, servo PWM.
// Depends on udc_pkg (phase codes, register indexes, result struct, clamp).
//
// One input transaction is one 1 us tick carrying the echo pin level; every tick
// yields exactly one registered result transaction. The block takes a new tick in
// every clock cycle unless the skid buffer is full: all state updates for a tick
// happen in one pass of logic into the state and result registers. Results leave
// through an output register backed by a one-entry skid buffer, so input is still
// taken while one result waits; input stalls only when both are full. The
// configuration port is always ready and writes one register per transaction;
// writes beyond index 7 are ignored.
module ultrasonic_door_controller #(
  parameter int PWM_PERIOD  = 20000,
  parameter int ECHO_LIMIT  = 60000,
  parameter int TRIG_WIDTH  = 10,
  parameter int TRIG_SETTLE = 2
) (
  input  logic        clk,
  input  logic        rst,
  // tick input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        echo_level,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        trigger_level,
  output logic        servo_pwm,
  output logic        door_open,
  output logic        measure_done,
  output logic        no_echo,
  output logic [15:0] echo_width,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int PWM_W = $clog2(PWM_PERIOD);

  localparam logic [20:0]    ECHO_LIM_C  = 21'(ECHO_LIMIT);
  localparam logic [15:0]    ECHO_LIM_W  = 16'(ECHO_LIMIT);
  localparam logic [20:0]    TRIG_W_C    = 21'(TRIG_WIDTH);
  localparam logic [20:0]    SETTLE_C    = 21'(TRIG_SETTLE);
  localparam logic [PWM_W:0] PWM_PER_C   = (PWM_W + 1)'(PWM_PERIOD);

  // Configuration registers
  logic [15:0] near_ticks;
  logic [15:0] far_ticks;
  logic [11:0] open_pulse_us;
  logic [11:0] closed_pulse_us;
  logic [15:0] echo_wait_limit;
  logic [19:0] closed_gap_us;
  logic [19:0] open_gap_us;
  logic [19:0] grace_us;

  // Controller state
  logic [2:0]       phase,        phase_next;
  logic [19:0]      phase_count,  phase_count_next;
  logic             door_is_open, door_is_open_next;
  logic             leaving,      leaving_next;
  logic [PWM_W-1:0] pwm_count,    pwm_count_next;
  logic [11:0]      servo_pulse,  servo_pulse_next;
  logic [15:0]      last_width,   last_width_next;

  // Output register and skid buffer
  udc_pkg::res_t out_res;
  udc_pkg::res_t skid_res;
  udc_pkg::res_t res_next;
  logic          skid_valid;

  logic        accept;
  logic [20:0] cnt_inc;
  logic [PWM_W:0] pwm_inc;
  logic        fin;
  logic        fin_tout;
  logic [15:0] fin_width;
  logic [15:0] meas_w;
  logic        trig;
  logic        pwm_bit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      near_ticks      <= udc_pkg::RST_NEAR_TICKS;
      far_ticks       <= udc_pkg::RST_FAR_TICKS;
      open_pulse_us   <= udc_pkg::RST_OPEN_PULSE_US;
      closed_pulse_us <= udc_pkg::RST_CLOSED_PULSE_US;
      echo_wait_limit <= udc_pkg::RST_ECHO_WAIT_LIMIT;
      closed_gap_us   <= udc_pkg::RST_CLOSED_GAP_US;
      open_gap_us     <= udc_pkg::RST_OPEN_GAP_US;
      grace_us        <= udc_pkg::RST_GRACE_US;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        udc_pkg::REG_NEAR_TICKS:      near_ticks      <= cfg_data[15:0];
        udc_pkg::REG_FAR_TICKS:       far_ticks       <= cfg_data[15:0];
        udc_pkg::REG_OPEN_PULSE_US:   open_pulse_us   <= cfg_data[11:0];
        udc_pkg::REG_CLOSED_PULSE_US: closed_pulse_us <= cfg_data[11:0];
        udc_pkg::REG_ECHO_WAIT_LIMIT: echo_wait_limit <= cfg_data[15:0];
        udc_pkg::REG_CLOSED_GAP_US:   closed_gap_us   <= cfg_data;
        udc_pkg::REG_OPEN_GAP_US:     open_gap_us     <= cfg_data;
        udc_pkg::REG_GRACE_US:        grace_us        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Servo PWM: level from values at tick start, period counter wraps
  always_comb begin
    pwm_bit = ({{(16 - PWM_W){1'b0}}, pwm_count} < {4'd0, servo_pulse});
    pwm_inc = {1'b0, pwm_count} + (PWM_W + 1)'(1);
    if (pwm_inc >= PWM_PER_C) begin
      pwm_count_next = '0;
    end else begin
      pwm_count_next = pwm_inc[PWM_W-1:0];
    end
  end

  // Ranging sequencer and door decision for one tick
  always_comb begin
    phase_next        = phase;
    phase_count_next  = phase_count;
    door_is_open_next = door_is_open;
    leaving_next      = leaving;
    servo_pulse_next  = servo_pulse;
    last_width_next   = last_width;
    trig      = 1'b0;
    fin       = 1'b0;
    fin_tout  = 1'b0;
    fin_width = '0;
    meas_w    = '0;
    cnt_inc   = {1'b0, phase_count} + 21'd1;

    unique case (phase)
      udc_pkg::PH_TRIG: begin
        trig = 1'b1;
        if (cnt_inc >= TRIG_W_C) begin
          phase_next       = udc_pkg::PH_WAIT;
          phase_count_next = '0;
        end else begin
          phase_count_next = cnt_inc[19:0];
        end
      end
      udc_pkg::PH_WAIT: begin
        if (echo_level) begin
          phase_next       = udc_pkg::PH_MEAS;
          phase_count_next = 20'd1;
          if (21'd1 >= ECHO_LIM_C) begin
            fin       = 1'b1;
            fin_width = ECHO_LIM_W;
          end
        end else begin
          phase_count_next = cnt_inc[19:0];
          if (cnt_inc >= {5'd0, echo_wait_limit}) begin
            fin      = 1'b1;
            fin_tout = 1'b1;
          end
        end
      end
      udc_pkg::PH_MEAS: begin
        if (echo_level) begin
          phase_count_next = cnt_inc[19:0];
          if (cnt_inc >= ECHO_LIM_C) begin
            fin       = 1'b1;
            fin_width = ECHO_LIM_W;
          end
        end else begin
          fin       = 1'b1;
          fin_width = phase_count[15:0];
        end
      end
      udc_pkg::PH_GAP: begin
        phase_count_next = cnt_inc[19:0];
        if (cnt_inc >= {1'b0, (door_is_open ? open_gap_us : closed_gap_us)}) begin
          phase_next       = udc_pkg::PH_SETTLE;
          phase_count_next = '0;
        end
      end
      udc_pkg::PH_GRACE: begin
        if (({1'b0, phase_count} >= {1'b0, grace_us}) || (cnt_inc >= {1'b0, grace_us})) begin
          // hold over: close and pause with the closed gap
          door_is_open_next = 1'b0;
          leaving_next      = 1'b0;
          servo_pulse_next  = udc_pkg::clamp_pulse(closed_pulse_us);
          phase_count_next  = '0;
          phase_next = (closed_gap_us == '0) ? udc_pkg::PH_SETTLE : udc_pkg::PH_GAP;
        end else begin
          phase_count_next = cnt_inc[19:0];
        end
      end
      default: begin
        // settle, and any undefined code
        phase_next       = udc_pkg::PH_SETTLE;
        phase_count_next = cnt_inc[19:0];
        if (cnt_inc >= SETTLE_C) begin
          phase_next       = udc_pkg::PH_TRIG;
          phase_count_next = '0;
        end
      end
    endcase

    // Measurement complete: record width and decide the door
    if (fin) begin
      meas_w           = fin_tout ? 16'd0 : fin_width;
      last_width_next  = meas_w;
      phase_count_next = '0;
      if (!door_is_open) begin
        if (!fin_tout && (meas_w != 16'd0) && (meas_w <= near_ticks)) begin
          door_is_open_next = 1'b1;
          servo_pulse_next  = udc_pkg::clamp_pulse(open_pulse_us);
          phase_next        = udc_pkg::PH_SETTLE;
        end else begin
          phase_next = (closed_gap_us == '0) ? udc_pkg::PH_SETTLE : udc_pkg::PH_GAP;
        end
      end else if (fin_tout || (meas_w >= far_ticks)) begin
        leaving_next = 1'b1;
        phase_next   = udc_pkg::PH_GRACE;
      end else begin
        phase_next = (open_gap_us == '0) ? udc_pkg::PH_SETTLE : udc_pkg::PH_GAP;
      end
    end

    res_next.trigger_level = trig;
    res_next.servo_pwm     = pwm_bit;
    res_next.door_open     = door_is_open_next;
    res_next.measure_done  = fin;
    res_next.no_echo       = fin_tout;
    res_next.echo_width    = last_width_next;
  end

  // State advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= udc_pkg::PH_SETTLE;
      phase_count  <= '0;
      door_is_open <= 1'b0;
      leaving      <= 1'b0;
      pwm_count    <= '0;
      servo_pulse  <= udc_pkg::PULSE_RESET;
      last_width   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      phase_count  <= phase_count_next;
      door_is_open <= door_is_open_next;
      leaving      <= leaving_next;
      pwm_count    <= pwm_count_next;
      servo_pulse  <= servo_pulse_next;
      last_width   <= last_width_next;
    end
  end

  // Output register with skid buffer: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output register with skid buffer: payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res_next;
      end
    end else if (accept) begin
      skid_res <= res_next;
    end
  end

  assign trigger_level = out_res.trigger_level;
  assign servo_pwm     = out_res.servo_pwm;
  assign door_open     = out_res.door_open;
  assign measure_done  = out_res.measure_done;
  assign no_echo       = out_res.no_echo;
  assign echo_width    = out_res.echo_width;

  // Assertions
  a_leave_needs_open: assert property (@(posedge clk) disable iff (rst)
    leaving |-> door_is_open)
    else $error("leaving set while door closed");

  a_grace_needs_leave: assert property (@(posedge clk) disable iff (rst)
    (phase == udc_pkg::PH_GRACE) |-> leaving)
    else $error("grace hold without leaving flag");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_no_echo_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.measure_done) |-> !out_res.no_echo)
    else $error("no_echo raised without measure_done");

  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    (servo_pulse >= udc_pkg::PULSE_MIN) && (servo_pulse <= udc_pkg::PULSE_MAX))
    else $error("servo pulse outside clamp range");

endmodule
